### sv/ksd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Koch segment subdivider.
// No dependencies; used by ksd_mul, ksd_engine and koch_segment_subdivider.
package ksd_pkg;

    localparam int DEPTH_LIMIT_DEF   = 3;
    localparam int FRACTION_BITS_DEF = 24;

    // Coefficients in 0.32 format; ksd_mul shifts them to its fraction width.
    localparam logic [63:0] COS60_Q32 = 64'd2147483648;
    localparam logic [63:0] SIN60_Q32 = 64'd3719550786;
    localparam logic [63:0] THIRD_Q32 = 64'd1431655765;

    typedef enum logic [1:0] {
        COEF_THIRD,
        COEF_COS,
        COEF_SIN
    } coef_t;

    typedef struct packed {
        logic signed [31:0] operand;
        coef_t              coef;
    } mul_req_t;

    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic [1:0]         depth;
    } stack_entry_t;

    typedef struct packed {
        logic signed [7:0] from_x;
        logic signed [7:0] from_y;
        logic signed [7:0] to_x;
        logic signed [7:0] to_y;
        logic              final_piece;
    } seg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP,
        ST_MUL_TX,
        ST_MUL_TY,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_MUL_D,
        ST_MUL_E,
        ST_PUSH_DB,
        ST_PUSH_ED,
        ST_PUSH_CE,
        ST_PUSH_AC
    } state_t;

    // Integer part of a fixed-point coordinate, wrapped to 8 bits.
    function automatic logic signed [7:0] to_pixel(input logic signed [31:0] v,
                                                   input int fb);
        logic signed [31:0] sh;
        sh = v >>> fb;
        return sh[7:0];
    endfunction

endpackage

### sv/ksd_mul.sv
`timescale 1ns / 1ps
// Shared fixed-point multiplier: operand times one of three constants.
// Depends on ksd_pkg. The product is registered, so the result appears in the cycle after the request.
module ksd_mul #(
    parameter int FRACTION_BITS = ksd_pkg::FRACTION_BITS_DEF
) (
    input  logic                clk,
    input  ksd_pkg::mul_req_t   req,
    output logic signed [31:0]  result
);

    localparam logic [31:0] K_COS   = 32'(ksd_pkg::COS60_Q32 >> (32 - FRACTION_BITS));
    localparam logic [31:0] K_SIN   = 32'(ksd_pkg::SIN60_Q32 >> (32 - FRACTION_BITS));
    localparam logic [31:0] K_THIRD = 32'(ksd_pkg::THIRD_Q32 >> (32 - FRACTION_BITS));

    logic [31:0]        coef;
    logic signed [32:0] coef_s;
    logic signed [63:0] prod_next;
    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_sh;

    always_comb
    begin
        unique case (req.coef)
            ksd_pkg::COEF_COS:   coef = K_COS;
            ksd_pkg::COEF_SIN:   coef = K_SIN;
            ksd_pkg::COEF_THIRD: coef = K_THIRD;
            default:             coef = K_THIRD;
        endcase
    end

    assign coef_s    = $signed({1'b0, coef});
    assign prod_next = req.operand * coef_s;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Floor shift of the full product, then keep the low word.
    assign prod_sh = prod_reg >>> FRACTION_BITS;
    assign result  = prod_sh[31:0];

endmodule

### sv/ksd_engine.sv
`timescale 1ns / 1ps
// Subdivision sequencer: segment stack, working registers and point adders.
// Depends on ksd_pkg; drives the shared ksd_mul through a request struct.
module ksd_engine #(
    parameter int DEPTH_LIMIT   = ksd_pkg::DEPTH_LIMIT_DEF,
    parameter int FRACTION_BITS = ksd_pkg::FRACTION_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ksd_pkg::stack_entry_t in_seg,
    output logic                  seg_valid,
    input  logic                  seg_ready,
    output ksd_pkg::seg_t         seg_out,
    output ksd_pkg::mul_req_t     mul_req,
    input  logic signed [31:0]    mul_res
);

    // Each level pops one segment and pushes four.
    localparam int STACK_DEPTH = 3 * DEPTH_LIMIT + 1;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    ksd_pkg::stack_entry_t stack_mem [STACK_DEPTH];

    ksd_pkg::state_t       state_reg, state_next;
    logic [SP_W-1:0]       sp_reg, sp_next, sp_dec;
    logic [IDX_W-1:0]      top_idx;
    ksd_pkg::stack_entry_t top;

    ksd_pkg::stack_entry_t w_reg, w_next;
    logic signed [31:0]    tx_reg, tx_next, ty_reg, ty_next;
    logic signed [31:0]    rx_reg, rx_next, ry_reg, ry_next;

    logic                  push_en;
    ksd_pkg::stack_entry_t push_entry;

    logic signed [31:0]    cx, cy, dx, dy, ex, ey;
    logic [1:0]            child_depth;
    logic [1:0]            in_depth;

    assign sp_dec  = sp_reg - SP_W'(1);
    assign top_idx = sp_dec[IDX_W-1:0];
    assign top     = stack_mem[top_idx];

    assign cx          = w_reg.x1 + tx_reg;
    assign cy          = w_reg.y1 + ty_reg;
    assign dx          = w_reg.x1 + {tx_reg[30:0], 1'b0};
    assign dy          = w_reg.y1 + {ty_reg[30:0], 1'b0};
    assign ex          = cx + rx_reg;
    assign ey          = cy + ry_reg;
    assign child_depth = w_reg.depth - 2'd1;
    assign in_depth    = (in_seg.depth > 2'(DEPTH_LIMIT)) ? 2'(DEPTH_LIMIT) : in_seg.depth;

    assign seg_out.from_x      = ksd_pkg::to_pixel(top.x1, FRACTION_BITS);
    assign seg_out.from_y      = ksd_pkg::to_pixel(top.y1, FRACTION_BITS);
    assign seg_out.to_x        = ksd_pkg::to_pixel(top.x2, FRACTION_BITS);
    assign seg_out.to_y        = ksd_pkg::to_pixel(top.y2, FRACTION_BITS);
    assign seg_out.final_piece = (sp_reg == SP_W'(1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ksd_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = ksd_pkg::ST_POP;
            end
            ksd_pkg::ST_POP:
            begin
                if (top.depth != 2'd0)
                    state_next = ksd_pkg::ST_MUL_TX;
                else if (seg_ready && sp_reg == SP_W'(1))
                    state_next = ksd_pkg::ST_IDLE;
            end
            ksd_pkg::ST_MUL_TX:  state_next = ksd_pkg::ST_MUL_TY;
            ksd_pkg::ST_MUL_TY:  state_next = ksd_pkg::ST_MUL_A;
            ksd_pkg::ST_MUL_A:   state_next = ksd_pkg::ST_MUL_B;
            ksd_pkg::ST_MUL_B:   state_next = ksd_pkg::ST_MUL_C;
            ksd_pkg::ST_MUL_C:   state_next = ksd_pkg::ST_MUL_D;
            ksd_pkg::ST_MUL_D:   state_next = ksd_pkg::ST_MUL_E;
            ksd_pkg::ST_MUL_E:   state_next = ksd_pkg::ST_PUSH_DB;
            ksd_pkg::ST_PUSH_DB: state_next = ksd_pkg::ST_PUSH_ED;
            ksd_pkg::ST_PUSH_ED: state_next = ksd_pkg::ST_PUSH_CE;
            ksd_pkg::ST_PUSH_CE: state_next = ksd_pkg::ST_PUSH_AC;
            ksd_pkg::ST_PUSH_AC: state_next = ksd_pkg::ST_POP;
            default:             state_next = ksd_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath control.
    always_comb
    begin
        in_ready        = 1'b0;
        seg_valid       = 1'b0;
        push_en         = 1'b0;
        push_entry      = in_seg;
        sp_next         = sp_reg;
        w_next          = w_reg;
        tx_next         = tx_reg;
        ty_next         = ty_reg;
        rx_next         = rx_reg;
        ry_next         = ry_reg;
        mul_req.operand = tx_reg;
        mul_req.coef    = ksd_pkg::COEF_THIRD;
        unique case (state_reg)
            ksd_pkg::ST_IDLE:
            begin
                in_ready         = 1'b1;
                push_entry.depth = in_depth;
                if (in_valid)
                begin
                    push_en = 1'b1;
                    sp_next = SP_W'(1);
                end
            end
            ksd_pkg::ST_POP:
            begin
                if (top.depth == 2'd0)
                begin
                    seg_valid = 1'b1;
                    if (seg_ready)
                        sp_next = sp_dec;
                end
                else
                begin
                    w_next  = top;
                    sp_next = sp_dec;
                end
            end
            ksd_pkg::ST_MUL_TX:
            begin
                mul_req.operand = w_reg.x2 - w_reg.x1;
            end
            ksd_pkg::ST_MUL_TY:
            begin
                mul_req.operand = w_reg.y2 - w_reg.y1;
                tx_next         = mul_res;
            end
            ksd_pkg::ST_MUL_A:
            begin
                mul_req.operand = tx_reg;
                mul_req.coef    = ksd_pkg::COEF_COS;
                ty_next         = mul_res;
            end
            ksd_pkg::ST_MUL_B:
            begin
                mul_req.operand = ty_reg;
                mul_req.coef    = ksd_pkg::COEF_SIN;
                rx_next         = mul_res;
            end
            ksd_pkg::ST_MUL_C:
            begin
                mul_req.operand = tx_reg;
                mul_req.coef    = ksd_pkg::COEF_SIN;
                rx_next         = rx_reg - mul_res;
            end
            ksd_pkg::ST_MUL_D:
            begin
                mul_req.operand = ty_reg;
                mul_req.coef    = ksd_pkg::COEF_COS;
                ry_next         = mul_res;
            end
            ksd_pkg::ST_MUL_E:
            begin
                ry_next = ry_reg + mul_res;
            end
            // Children go on in reverse so the first piece is popped first.
            ksd_pkg::ST_PUSH_DB:
            begin
                push_en    = 1'b1;
                push_entry = '{x1: dx, y1: dy, x2: w_reg.x2, y2: w_reg.y2,
                               depth: child_depth};
                sp_next    = sp_reg + SP_W'(1);
            end
            ksd_pkg::ST_PUSH_ED:
            begin
                push_en    = 1'b1;
                push_entry = '{x1: ex, y1: ey, x2: dx, y2: dy, depth: child_depth};
                sp_next    = sp_reg + SP_W'(1);
            end
            ksd_pkg::ST_PUSH_CE:
            begin
                push_en    = 1'b1;
                push_entry = '{x1: cx, y1: cy, x2: ex, y2: ey, depth: child_depth};
                sp_next    = sp_reg + SP_W'(1);
            end
            ksd_pkg::ST_PUSH_AC:
            begin
                push_en    = 1'b1;
                push_entry = '{x1: w_reg.x1, y1: w_reg.y1, x2: cx, y2: cy,
                               depth: child_depth};
                sp_next    = sp_reg + SP_W'(1);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ksd_pkg::ST_IDLE;
            sp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg  <= w_next;
        tx_reg <= tx_next;
        ty_reg <= ty_next;
        rx_reg <= rx_next;
        ry_reg <= ry_next;
        if (push_en)
            stack_mem[sp_reg[IDX_W-1:0]] <= push_entry;
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("segment stack overflow");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ksd_pkg::ST_IDLE |-> sp_reg == '0)
        else $error("stack not empty while idle");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ksd_pkg::ST_POP && sp_reg == SP_W'(1))
        else $error("accepted segment not loaded on stack");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && seg_ready && seg_out.final_piece |=> state_reg == ksd_pkg::ST_IDLE)
        else $error("last word did not end the run");

    a_split_depth: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ksd_pkg::ST_PUSH_DB |-> w_reg.depth != 2'd0)
        else $error("split of a leaf segment");

endmodule

### sv/koch_segment_subdivider.sv
`timescale 1ns / 1ps
// Top level of the Koch segment subdivider: stream ports and output register.
// Depends on ksd_pkg, ksd_mul and ksd_engine.
//
// One input word carries a segment and a level count; the block answers with
// 4^level output words, the pieces of the Koch curve in drawing order, with
// tlast on the final piece. Work runs on one shared multiplier under a
// sequencer with a segment stack, and s_tready stays low until the last word
// of a run has been handed to the output register. Each split of a segment
// runs one pop, seven multiplier steps and four stack pushes, and each
// emitted piece takes one pop, which waits while the output register is full
// and m_tready is low.
module koch_segment_subdivider #(
    parameter int DEPTH_LIMIT   = ksd_pkg::DEPTH_LIMIT_DEF,
    parameter int FRACTION_BITS = ksd_pkg::FRACTION_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_x, start_y, end_x, end_y, level_count[1:0], zero padding
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // from_x, from_y, to_x, to_y
    output logic [31:0]  m_tdata,
    output logic         m_tlast
);

    ksd_pkg::stack_entry_t in_seg;
    ksd_pkg::seg_t         seg_out;
    ksd_pkg::seg_t         out_reg;
    ksd_pkg::mul_req_t     mul_req;
    logic signed [31:0]    mul_res;
    logic                  seg_valid, seg_ready;
    logic                  m_valid_reg, m_valid_next;

    assign in_seg.x1    = s_tdata[31:0];
    assign in_seg.y1    = s_tdata[63:32];
    assign in_seg.x2    = s_tdata[95:64];
    assign in_seg.y2    = s_tdata[127:96];
    assign in_seg.depth = s_tdata[129:128];

    ksd_mul #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mul (
        .clk    (clk),
        .req    (mul_req),
        .result (mul_res)
    );

    ksd_engine #(
        .DEPTH_LIMIT  (DEPTH_LIMIT),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_seg   (in_seg),
        .seg_valid(seg_valid),
        .seg_ready(seg_ready),
        .seg_out  (seg_out),
        .mul_req  (mul_req),
        .mul_res  (mul_res)
    );

    // The output register takes a new word whenever it is empty or draining.
    assign seg_ready    = !m_valid_reg || m_tready;
    assign m_valid_next = seg_valid || (m_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (seg_valid && seg_ready)
            out_reg <= seg_out;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_reg.to_y, out_reg.to_x, out_reg.from_y, out_reg.from_x};
    assign m_tlast  = out_reg.final_piece;

endmodule
